/* rtl/core/hcbp_pkg.sv */
package hcbp_pkg;

  // fixed word width of the packed output
  localparam int WORD_BITS = 32;
  localparam int LEN_W     = 6;

  // operation codes on func
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  // end symbol after reset
  localparam logic [7:0] END_SYMBOL_RST = 8'd3;

  // result queue depth and pointer widths
  localparam int OFIFO_DEPTH = 8;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = OFIFO_PTR_W + 1;

  // one code table entry: clamped length and masked, right-aligned code
  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [WORD_BITS-1:0] code;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } res_t;

  // results pushed into the queue in one cycle (0, 1 or 2)
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // build a table entry from a load item
  function automatic entry_t make_entry(input logic [WORD_BITS-1:0] code,
                                        input logic [LEN_W-1:0]     len);
    entry_t     e;
    logic [LEN_W-1:0] lc;
    logic [2*WORD_BITS-1:0] m;
    lc = (len > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS) : len;
    m  = ({{(2*WORD_BITS-1){1'b0}}, 1'b1} << lc) - {{(2*WORD_BITS-1){1'b0}}, 1'b1};
    e.len  = lc;
    e.code = code & m[WORD_BITS-1:0];
    return e;
  endfunction

endpackage

/* rtl/core/hcbp_if.sv */
interface hcbp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol;
  logic [31:0] code_bits;
  logic [5:0] code_length;

  modport source (output valid, func, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  logic        last;

  modport source (output valid, packed_word, last, input ready);
  modport sink   (input valid, packed_word, last, output ready);
endinterface

/* rtl/core/hcbp_table.sv */
module hcbp_table #(
  parameter int SYMBOL_COUNT = 256,
  parameter int AW = $clog2(SYMBOL_COUNT)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  hcbp_pkg::entry_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output hcbp_pkg::entry_t rd_data
);

  hcbp_pkg::entry_t mem [SYMBOL_COUNT];
  hcbp_pkg::entry_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/hcbp_pack.sv */
module hcbp_pack (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_en,
  input  logic [1:0]       acc_func,
  input  logic             acc_hit,
  input  hcbp_pkg::entry_t entry,
  output logic             busy,
  output hcbp_pkg::push_t  push
);

  localparam int W = hcbp_pkg::WORD_BITS;
  localparam int LW = hcbp_pkg::LEN_W;

  logic         vld_r;
  logic [1:0]   func_r;
  logic         hit_r;
  logic [W-1:0] acc_r, acc_nxt;
  logic [4:0]   fill_r, fill_nxt;

  logic [LW-1:0]  len;
  logic [2*W-1:0] acc64, shifted;
  logic [LW-1:0]  total;
  logic [4:0]     rem;
  logic           full;
  logic [W-1:0]   word_a, acc_a, rem_mask, pad;
  logic [LW-1:0]  pad_sh;

  // item stage, lines up with the table read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= acc_en;
    end
    func_r <= acc_func;
    hit_r  <= acc_hit;
  end

  assign busy = vld_r;

  // append the entry code to the pending bits
  always_comb begin
    len      = hit_r ? entry.len : '0;
    acc64    = ({{W{1'b0}}, acc_r} << len) | {{W{1'b0}}, (hit_r ? entry.code : '0)};
    total    = {1'b0, fill_r} + len;
    full     = total[5];
    rem      = total[4:0];
    shifted  = acc64 >> rem;
    word_a   = shifted[W-1:0];
    rem_mask = (W'(1) << rem) - W'(1);
    acc_a    = full ? (acc64[W-1:0] & rem_mask) : acc64[W-1:0];
    pad_sh   = LW'(W) - {1'b0, rem};
    pad      = acc_a << pad_sh;
  end

  // results and next packer state
  always_comb begin
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    push     = '0;
    push.r0.word = word_a;
    push.r1.word = pad;
    if (vld_r) begin
      case (func_r)
        hcbp_pkg::FUNC_ENCODE: begin
          acc_nxt  = acc_a;
          fill_nxt = rem;
          push.cnt = {1'b0, full};
        end
        hcbp_pkg::FUNC_FINISH: begin
          acc_nxt  = '0;
          fill_nxt = '0;
          if (full && rem != 5'd0) begin
            push.cnt     = 2'd2;
            push.r1.last = 1'b1;
          end else if (full) begin
            push.cnt     = 2'd1;
            push.r0.last = 1'b1;
          end else if (rem != 5'd0) begin
            push.cnt     = 2'd1;
            push.r0.word = pad;
            push.r0.last = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      fill_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

/* rtl/core/hcbp_ofifo.sv */
module hcbp_ofifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hcbp_pkg::push_t                   push,
  input  logic                              pop,
  output logic                              not_empty,
  output hcbp_pkg::res_t                    head,
  output logic [hcbp_pkg::OFIFO_CNT_W-1:0]  count
);

  localparam int PW = hcbp_pkg::OFIFO_PTR_W;
  localparam int CW = hcbp_pkg::OFIFO_CNT_W;

  hcbp_pkg::res_t mem [hcbp_pkg::OFIFO_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic [PW-1:0]  wp1;

  assign wp1 = wp_r + PW'(1);

  // up to two writes a cycle
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp1] <= push.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PW'(push.cnt);
      rp_r  <= rp_r + PW'(pop);
      cnt_r <= cnt_r + CW'(push.cnt) - CW'(pop);
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = mem[rp_r];
  assign count     = cnt_r;

endmodule

/* rtl/core/huffman_code_bit_packer_top.sv */
// Huffman code bit packer with 32-bit output words.
// in_ch carries one item per handshake: func selects load (write one code
// table entry), encode (append the code of symbol) or finish (append the
// code of the end symbol, flush the partial word left-aligned with last set
// and clear the packer). out_ch returns packed words, first bit at the MSB.
// cfg_wr_en/cfg_wr_data set the end symbol, which is 3 after reset.
// One item is taken per cycle while in_ch.ready is high. An item reads its
// table entry at the accept edge; the append runs in the next cycle and its
// results (0, 1 or 2 words) enter an 8-entry result queue, which registers
// them before out_ch can take the first word. The queue parts the two sides:
// while out_ch stalls, items keep coming in until the queue has no room for
// the worst case: two words from the item in flight, two from the new one.
// Reset clears the packer and the queue and sets the end symbol to 3; the
// code table holds no defined contents until entries are loaded, and a
// symbol must be loaded before it is encoded.
module huffman_code_bit_packer_top #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  hcbp_in_if.sink           in_ch,
  hcbp_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  localparam int AW = $clog2(SYMBOL_COUNT);
  localparam int CW = hcbp_pkg::OFIFO_CNT_W;

  logic [7:0]       end_symbol_r;
  logic             accept;
  logic [7:0]       idx;
  logic             hit;
  logic             wr_en;
  hcbp_pkg::entry_t wr_entry;
  hcbp_pkg::entry_t rd_entry;
  logic             busy;
  hcbp_pkg::push_t  push;
  logic             not_empty;
  hcbp_pkg::res_t   head;
  logic [CW-1:0]    count;
  logic [CW-1:0]    reserved;

  // end symbol register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_symbol_r <= hcbp_pkg::END_SYMBOL_RST;
    end else if (cfg_wr_en) begin
      end_symbol_r <= cfg_wr_data;
    end
  end

  // room for two words from the item in flight and two from a new one
  assign reserved    = count + (busy ? CW'(2) : CW'(0));
  assign in_ch.ready = (reserved <= CW'(hcbp_pkg::OFIFO_DEPTH - 2));
  assign accept      = in_ch.valid && in_ch.ready;

  // table index and range check
  assign idx   = (in_ch.func == hcbp_pkg::FUNC_FINISH) ? end_symbol_r : in_ch.symbol;
  assign hit   = (32'(idx) < SYMBOL_COUNT);
  assign wr_en = accept && (in_ch.func == hcbp_pkg::FUNC_LOAD) && hit;
  assign wr_entry = hcbp_pkg::make_entry(in_ch.code_bits, in_ch.code_length);

  hcbp_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .AW           (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx[AW-1:0]),
    .wr_data (wr_entry),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_entry)
  );

  hcbp_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_en   (accept),
    .acc_func (in_ch.func),
    .acc_hit  (hit),
    .entry    (rd_entry),
    .busy     (busy),
    .push     (push)
  );

  hcbp_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_ch.valid && out_ch.ready),
    .not_empty (not_empty),
    .head      (head),
    .count     (count)
  );

  // result channel
  assign out_ch.valid       = not_empty;
  assign out_ch.packed_word = head.word;
  assign out_ch.last        = head.last;

endmodule
